// ===== rtl/pdct_pkg.sv =====
package pdct_pkg;

    // Counter width; the bus read data carries its low 16 bits
    localparam int COUNT_WIDTH = 16;
    localparam int RDATA_WIDTH = 16;

    // Item kinds
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Access widths
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_MISALIGNED  = 2'd1;
    localparam logic [1:0] ST_UNMAPPED    = 2'd2;
    localparam logic [1:0] ST_UNPERMITTED = 2'd3;

    // Register indexes (address bits 3:2)
    localparam logic [1:0] REG_LOAD    = 2'd0;
    localparam logic [1:0] REG_COUNTER = 2'd1;
    localparam logic [1:0] REG_CONTROL = 2'd2;
    localparam logic [1:0] REG_CLEAR   = 2'd3;

    // Control register bit positions
    localparam int CTRL_ENABLE   = 7;
    localparam int CTRL_PERIODIC = 6;
    localparam int CTRL_PSEL_LO  = 2;

    // Prescale selects
    localparam logic [1:0] PSEL_DIV1  = 2'd0;
    localparam logic [1:0] PSEL_DIV16 = 2'd1;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [1:0]  access_size;
    } t_in_item;

    typedef struct packed {
        logic [RDATA_WIDTH-1:0] rdata;
        logic [1:0]             status;
        logic                   irq;
    } t_out_item;

    // Decoded access from the check stage to the timer core
    typedef struct packed {
        logic       rd;
        logic       wr;
        logic       tick;
        logic [1:0] sel;
        logic [1:0] status;
    } t_dec;

endpackage

// ===== rtl/pdct_check.sv =====
module pdct_check (
    input  pdct_pkg::t_in_item i_item,
    output pdct_pkg::t_dec     o_dec
);
    import pdct_pkg::*;

    logic w_bus;
    logic [1:0] w_status;

    // Check width, then alignment, then range
    always_comb begin
        w_bus = (i_item.func == FUNC_READ) || (i_item.func == FUNC_WRITE);
        w_status = ST_OK;
        if (w_bus) begin
            priority if (i_item.access_size != SIZE_WORD) begin
                w_status = ST_UNPERMITTED;
            end else if (i_item.addr[1:0] != 2'd0) begin
                w_status = ST_MISALIGNED;
            end else if (i_item.addr[31:4] != 28'd0) begin
                w_status = ST_UNMAPPED;
            end else begin
                w_status = ST_OK;
            end
        end
    end

    assign o_dec.status = w_status;
    assign o_dec.rd     = (i_item.func == FUNC_READ)  && (w_status == ST_OK);
    assign o_dec.wr     = (i_item.func == FUNC_WRITE) && (w_status == ST_OK);
    assign o_dec.tick   = (i_item.func == FUNC_TICK);
    assign o_dec.sel    = i_item.addr[3:2];

endmodule

// ===== rtl/pdct_core.sv =====
module pdct_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  pdct_pkg::t_in_item  i_item,
    input  pdct_pkg::t_dec      i_dec,
    output pdct_pkg::t_out_item o_res
);
    import pdct_pkg::*;

    logic [COUNT_WIDTH-1:0] r_reload;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_enable;
    logic                   r_periodic;
    logic [1:0]             r_psel;
    logic [7:0]             r_pcount;
    logic                   r_irq;

    logic [COUNT_WIDTH-1:0] n_reload;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   n_enable;
    logic                   n_periodic;
    logic [1:0]             n_psel;
    logic [7:0]             n_pcount;
    logic                   n_irq;

    logic [7:0]             w_div_m1;
    logic [COUNT_WIDTH-1:0] w_count_dec;
    logic [RDATA_WIDTH-1:0] w_rdata;

    // Prescaler terminal count; select 3 behaves as divide by 256
    always_comb begin
        unique case (r_psel)
            PSEL_DIV1:  w_div_m1 = 8'd0;
            PSEL_DIV16: w_div_m1 = 8'd15;
            default:    w_div_m1 = 8'd255;
        endcase
    end

    assign w_count_dec = r_count - COUNT_WIDTH'(1);

    // Next state for the item under way
    always_comb begin
        n_reload   = r_reload;
        n_count    = r_count;
        n_enable   = r_enable;
        n_periodic = r_periodic;
        n_psel     = r_psel;
        n_pcount   = r_pcount;
        n_irq      = r_irq;
        if (i_dec.wr) begin
            unique case (i_dec.sel)
                REG_LOAD: begin
                    n_reload = i_item.wdata[COUNT_WIDTH-1:0];
                    n_count  = i_item.wdata[COUNT_WIDTH-1:0];
                end
                REG_CONTROL: begin
                    n_enable   = i_item.wdata[CTRL_ENABLE];
                    n_periodic = i_item.wdata[CTRL_PERIODIC];
                    n_psel     = i_item.wdata[CTRL_PSEL_LO+1:CTRL_PSEL_LO];
                    n_pcount   = 8'd0;
                end
                REG_CLEAR: begin
                    n_irq = 1'b0;
                end
                default: begin
                end
            endcase
        end else if (i_dec.tick && r_enable) begin
            if (r_pcount < w_div_m1) begin
                n_pcount = r_pcount + 8'd1;
            end else begin
                n_pcount = 8'd0;
                // Advance the counter; on reaching zero reload or roll over
                if (w_count_dec == '0) begin
                    if (r_periodic) begin
                        n_count = r_reload;
                        n_irq   = 1'b1;
                    end else begin
                        n_count = '1;
                    end
                end else begin
                    n_count = w_count_dec;
                end
            end
        end
    end

    // Read mux
    always_comb begin
        w_rdata = '0;
        if (i_dec.rd) begin
            unique case (i_dec.sel)
                REG_LOAD:    w_rdata = RDATA_WIDTH'(r_reload);
                REG_COUNTER: w_rdata = RDATA_WIDTH'(r_count);
                REG_CONTROL: w_rdata = {8'd0, r_enable, r_periodic, 2'd0, r_psel, 2'd0};
                default:     w_rdata = '0;
            endcase
        end
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload   <= '0;
            r_count    <= '0;
            r_enable   <= 1'b0;
            r_periodic <= 1'b0;
            r_psel     <= 2'd0;
            r_pcount   <= 8'd0;
            r_irq      <= 1'b0;
        end else if (i_adv) begin
            r_reload   <= n_reload;
            r_count    <= n_count;
            r_enable   <= n_enable;
            r_periodic <= n_periodic;
            r_psel     <= n_psel;
            r_pcount   <= n_pcount;
            r_irq      <= n_irq;
        end
    end

    assign o_res.rdata  = w_rdata;
    assign o_res.status = i_dec.status;
    assign o_res.irq    = n_irq;

endmodule

// ===== rtl/prescaled_down_counter_timer.sv =====
// The result passes through the input register, then the result register;
// the decode and counter update sit between the two registers.
// Throughput: one item per cycle while the receiver takes results; the timer
// state updates as each item moves into the result register, so back-to-back
// items see each other.
// Reset (i_rst_n low, synchronous) clears all timer registers, the interrupt
// and both valid flags.
module prescaled_down_counter_timer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pdct_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pdct_pkg::t_out_item o_out_item
);
    import pdct_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      w_adv;
    t_dec      w_dec;
    t_out_item w_res;

    // Move the held item on when the result register is free or drains
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    pdct_check u_check (
        .i_item (r_in_item),
        .o_dec  (w_dec)
    );

    pdct_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_in_item),
        .i_dec   (w_dec),
        .o_res   (w_res)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (w_adv) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/pdct_checker.sv =====
module pdct_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input pdct_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input pdct_pkg::t_out_item o_out_item
);
    import pdct_pkg::*;

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Drop input ready only when a result is stuck downstream
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Failed accesses read as zero
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != ST_OK) |-> o_out_item.rdata == '0)
        else $error("nonzero read data on failed access");

endmodule

bind prescaled_down_counter_timer pdct_checker u_pdct_checker (.*);

// ===== verif/prescaled_down_counter_timer_tb.sv =====
`timescale 1ns / 100ps

module prescaled_down_counter_timer_tb;

    import pdct_pkg::*;

    // Access widths and item kind that the package leaves unnamed
    localparam logic [1:0] SIZE_BYTE   = 2'd0;
    localparam logic [1:0] SIZE_HALF   = 2'd1;
    localparam logic [1:0] SIZE_DWORD  = 2'd3;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Register byte addresses, built from the register indexes
    localparam logic [31:0] ADDR_LOAD    = {28'd0, REG_LOAD, 2'b00};
    localparam logic [31:0] ADDR_COUNTER = {28'd0, REG_COUNTER, 2'b00};
    localparam logic [31:0] ADDR_CONTROL = {28'd0, REG_CONTROL, 2'b00};
    localparam logic [31:0] ADDR_CLEAR   = {28'd0, REG_CLEAR, 2'b00};

    localparam logic [1:0] PSEL_DIV256   = 2'd2;
    localparam logic [1:0] PSEL_DIV256_B = 2'd3;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 8;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // Predicted timer state
    logic [COUNT_WIDTH-1:0] reload_q;
    logic [COUNT_WIDTH-1:0] count_q;
    logic                   enable_q;
    logic                   periodic_q;
    logic [1:0]             psel_q;
    logic [7:0]             prescale_q;
    logic                   irq_q;

    t_out_item pending_results[$];

    int errors          = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int expiries        = 0;
    int cycles          = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;

    prescaled_down_counter_timer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Work out the result of one item and advance the predicted state
    function automatic t_out_item predict_timer(input t_in_item it);
        t_out_item  res;
        logic [7:0] div_top;
        res = '0;
        if (it.func == FUNC_READ || it.func == FUNC_WRITE) begin
            if (it.access_size != SIZE_WORD)
                res.status = ST_UNPERMITTED;
            else if (it.addr[1:0] != 2'b00)
                res.status = ST_MISALIGNED;
            else if (it.addr > ADDR_CLEAR)
                res.status = ST_UNMAPPED;
            else
                res.status = ST_OK;
            if (res.status == ST_OK && it.func == FUNC_READ) begin
                case (it.addr[3:2])
                    REG_LOAD: res.rdata = reload_q[RDATA_WIDTH-1:0];
                    REG_COUNTER: res.rdata = count_q[RDATA_WIDTH-1:0];
                    REG_CONTROL: begin
                        res.rdata[CTRL_ENABLE]         = enable_q;
                        res.rdata[CTRL_PERIODIC]       = periodic_q;
                        res.rdata[CTRL_PSEL_LO +: 2]   = psel_q;
                    end
                    default: res.rdata = '0;
                endcase
            end else if (res.status == ST_OK) begin
                case (it.addr[3:2])
                    REG_LOAD: begin
                        reload_q = it.wdata[COUNT_WIDTH-1:0];
                        count_q  = it.wdata[COUNT_WIDTH-1:0];
                    end
                    REG_CONTROL: begin
                        psel_q     = it.wdata[CTRL_PSEL_LO +: 2];
                        enable_q   = it.wdata[CTRL_ENABLE];
                        periodic_q = it.wdata[CTRL_PERIODIC];
                        prescale_q = '0;
                    end
                    REG_CLEAR: irq_q = 1'b0;
                    default: ;
                endcase
            end
        end else if (it.func == FUNC_TICK && enable_q) begin
            div_top = (psel_q == PSEL_DIV1) ? 8'd0 : (psel_q == PSEL_DIV16) ? 8'd15 : 8'd255;
            if (prescale_q < div_top) begin
                prescale_q = prescale_q + 8'd1;
            end else begin
                prescale_q = '0;
                count_q    = count_q - 1'b1;
                if (count_q == '0) begin
                    if (periodic_q) begin
                        count_q = reload_q;
                        irq_q   = 1'b1;
                        expiries++;
                    end else begin
                        count_q = '1;
                    end
                end
            end
        end
        res.irq = irq_q;
        return res;
    endfunction

    initial begin
        reload_q   = '0;
        count_q    = '0;
        enable_q   = 1'b0;
        periodic_q = 1'b0;
        psel_q     = '0;
        prescale_q = '0;
        irq_q      = 1'b0;
    end

    // Check each result against the oldest prediction, then log new items
    always @(posedge i_clk) begin
        t_out_item want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_checked++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing pending, got %h", $time, out_item);
                end else begin
                    want = pending_results.pop_front();
                    if (out_item.rdata !== want.rdata) begin
                        errors++;
                        $display("%0t: rdata mismatch, expected %h, got %h",
                                 $time, want.rdata, out_item.rdata);
                    end
                    if (out_item.status !== want.status) begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, out_item.status);
                    end
                    if (out_item.irq !== want.irq) begin
                        errors++;
                        $display("%0t: irq mismatch, expected %b, got %b",
                                 $time, want.irq, out_item.irq);
                    end
                end
            end
            if (in_valid && in_ready)
                pending_results.insert(pending_results.size(), predict_timer(in_item));
        end
    end

    // Receiver stalls
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Guard against a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("prescaled_down_counter_timer test failed");
            $finish;
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Offer one item, with random gaps ahead of it, and hold until accepted
    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic bus_access(input logic [1:0] func, input logic [31:0] addr,
                              input logic [31:0] wdata, input logic [1:0] size);
        t_in_item it;
        it.func        = func;
        it.addr        = addr;
        it.wdata       = wdata;
        it.access_size = size;
        send_item(it);
    endtask

    // Ticks carry junk in the unused fields
    task automatic run_ticks(input int n);
        repeat (n) bus_access(FUNC_TICK, $urandom, $urandom, 2'($urandom_range(0, 3)));
    endtask

    function automatic logic [31:0] ctrl_word(input logic en, input logic per,
                                              input logic [1:0] psel);
        logic [31:0] w;
        w = '0;
        w[CTRL_ENABLE]       = en;
        w[CTRL_PERIODIC]     = per;
        w[CTRL_PSEL_LO +: 2] = psel;
        return w;
    endfunction

    task automatic test_reset_values();
        bus_access(FUNC_READ, ADDR_LOAD, '0, SIZE_WORD);
        bus_access(FUNC_READ, ADDR_COUNTER, '0, SIZE_WORD);
        bus_access(FUNC_READ, ADDR_CONTROL, '0, SIZE_WORD);
        bus_access(FUNC_READ, ADDR_CLEAR, '0, SIZE_WORD);
        bus_access(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_DWORD);
    endtask

    // Width is checked before alignment, alignment before the map
    task automatic test_access_errors();
        bus_access(FUNC_READ, ADDR_LOAD, '0, SIZE_BYTE);
        bus_access(FUNC_WRITE, ADDR_LOAD, 32'h0000_1234, SIZE_HALF);
        bus_access(FUNC_READ, ADDR_CONTROL, '0, SIZE_DWORD);
        bus_access(FUNC_READ, 32'h0000_0001, '0, SIZE_WORD);
        bus_access(FUNC_WRITE, 32'h0000_0002, 32'hFFFF_FFFF, SIZE_WORD);
        bus_access(FUNC_READ, 32'h0000_0010, '0, SIZE_WORD);
        bus_access(FUNC_WRITE, 32'hFFFF_FFFC, 32'h0000_00C0, SIZE_WORD);
        bus_access(FUNC_READ, 32'hFFFF_FFFF, '0, SIZE_WORD);
        bus_access(FUNC_READ, 32'hFFFF_FFFF, '0, SIZE_HALF);
    endtask

    task automatic test_register_writes();
        bus_access(FUNC_WRITE, ADDR_LOAD, 32'hFFFF_FFFF, SIZE_WORD);
        bus_access(FUNC_WRITE, ADDR_COUNTER, 32'h0000_1234, SIZE_WORD);
        run_ticks(1);
        bus_access(FUNC_READ, ADDR_COUNTER, '0, SIZE_WORD);
        bus_access(FUNC_WRITE, ADDR_CONTROL, 32'hFFFF_FF7F, SIZE_WORD);
        bus_access(FUNC_READ, ADDR_CONTROL, '0, SIZE_WORD);
    endtask

    task automatic test_expiry_modes();
        // free running: wrap to all ones, interrupt stays low
        bus_access(FUNC_WRITE, ADDR_LOAD, 32'd1, SIZE_WORD);
        bus_access(FUNC_WRITE, ADDR_CONTROL, ctrl_word(1'b1, 1'b0, PSEL_DIV1), SIZE_WORD);
        run_ticks(1);
        bus_access(FUNC_READ, ADDR_COUNTER, '0, SIZE_WORD);
        // periodic: reload and raise the interrupt, then clear it
        bus_access(FUNC_WRITE, ADDR_LOAD, 32'd2, SIZE_WORD);
        bus_access(FUNC_WRITE, ADDR_CONTROL, ctrl_word(1'b1, 1'b1, PSEL_DIV1), SIZE_WORD);
        run_ticks(3);
        bus_access(FUNC_WRITE, ADDR_CLEAR, 32'hFFFF_FFFF, SIZE_WORD);
        // disabled: ticks change nothing
        bus_access(FUNC_WRITE, ADDR_CONTROL, ctrl_word(1'b0, 1'b1, PSEL_DIV1), SIZE_WORD);
        run_ticks(1);
        bus_access(FUNC_READ, ADDR_COUNTER, '0, SIZE_WORD);
    endtask

    // Load zero in periodic mode: the first decrement wraps to all ones
    task automatic test_zero_reload_wrap();
        bus_access(FUNC_WRITE, ADDR_LOAD, 32'd0, SIZE_WORD);
        bus_access(FUNC_WRITE, ADDR_CONTROL, ctrl_word(1'b1, 1'b1, PSEL_DIV1), SIZE_WORD);
        run_ticks(1);
        bus_access(FUNC_READ, ADDR_COUNTER, '0, SIZE_WORD);
        run_ticks(2);
        bus_access(FUNC_READ, ADDR_COUNTER, '0, SIZE_WORD);
        bus_access(FUNC_WRITE, ADDR_CLEAR, '0, SIZE_WORD);
    endtask

    // Mostly ticks and well-formed register traffic with short loads and
    // fast prescales so that expiries come often; the rest is noise
    task automatic test_random_traffic(input int n);
        int          pick;
        logic [31:0] w;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 52) begin
                run_ticks(1);
            end else if (pick < 61) begin
                w = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 24);
                bus_access(FUNC_WRITE, ADDR_LOAD, w, SIZE_WORD);
            end else if (pick < 68) begin
                w = $urandom;
                w[CTRL_ENABLE] = ($urandom_range(0, 4) != 0);
                w[CTRL_PSEL_LO +: 2] = ($urandom_range(0, 9) < 8) ?
                                       2'($urandom_range(0, 1)) :
                                       (($urandom_range(0, 1) == 0) ? PSEL_DIV256
                                                                    : PSEL_DIV256_B);
                bus_access(FUNC_WRITE, ADDR_CONTROL, w, SIZE_WORD);
            end else if (pick < 73) begin
                bus_access(FUNC_WRITE, ADDR_CLEAR, $urandom, SIZE_WORD);
            end else if (pick < 86) begin
                bus_access(FUNC_READ, {28'd0, 2'($urandom_range(0, 3)), 2'b00},
                           $urandom, SIZE_WORD);
            end else if (pick < 88) begin
                bus_access(FUNC_WRITE, ADDR_COUNTER, $urandom, SIZE_WORD);
            end else if (pick < 97) begin
                bus_access(2'($urandom_range(0, 1)), $urandom, $urandom,
                           2'($urandom_range(0, 3)));
            end else begin
                bus_access(FUNC_UNUSED, $urandom, $urandom, 2'($urandom_range(0, 3)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        set_idling(13, 60);
        test_reset_values();
        test_access_errors();
        test_register_writes();
        test_expiry_modes();
        test_zero_reload_wrap();

        test_random_traffic(555);
        set_idling(60, 13);
        test_random_traffic(555);
        set_idling(0, 0);
        test_random_traffic(555);

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items (register accesses, access errors, base ticks)", items_sent);
        $display("Checked %0d results, %0d periodic expiries raised the interrupt",
                 results_checked, expiries);
        if (errors == 0) begin
            $display("prescaled_down_counter_timer test passed");
        end else begin
            $display("prescaled_down_counter_timer test failed");
        end
        $finish;
    end

endmodule
